/* src/sgzf_pkg.sv */
package sgzf_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int GAIN_W      = 16;
  localparam int DUTY_W      = 8;
  localparam int FORCE_W     = 16;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [1:0] REQ_MEASURE = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_STEP    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MEASURED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_INITIAL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_INITIAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_UPPER     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOWER     = 3'd4;

  localparam logic [SAMPLE_BITS-1:0] ZERO_UPPER_RST = SAMPLE_BITS'(200);
  localparam logic [SAMPLE_BITS-1:0] ZERO_LOWER_RST = SAMPLE_BITS'(190);
  localparam logic [DUTY_W-1:0]      DUTY_MAX       = '1;
  localparam logic [FORCE_W-1:0]     FORCE_MAX      = '1;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [SAMPLE_BITS-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [FORCE_W-1:0]     force_res;
    logic                   force_saturated;
    logic [DUTY_W-1:0]      bias_duty;
    logic [SAMPLE_BITS-1:0] zero_offset;
    logic [STATUS_W-1:0]    status;
  } res_t;

  typedef struct packed {
    logic [DUTY_W-1:0]      duty;
    logic [SAMPLE_BITS-1:0] offset;
    logic [STATUS_W-1:0]    status;
  } tag_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] clean;
    tag_t                   tag;
  } work_t;

endpackage

/* src/sgzf_ctrl.sv */
module sgzf_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sgzf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgzf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                take,
  input  sgzf_pkg::req_t                      item,
  output sgzf_pkg::work_t                     work,
  output logic [sgzf_pkg::GAIN_W-1:0]         gain
);

  logic [sgzf_pkg::SAMPLE_BITS-1:0] zero_upper;
  logic [sgzf_pkg::SAMPLE_BITS-1:0] zero_lower;
  logic [sgzf_pkg::DUTY_W-1:0]      duty;
  logic [sgzf_pkg::DUTY_W-1:0]      duty_next;
  logic [sgzf_pkg::SAMPLE_BITS-1:0] offset;
  logic [sgzf_pkg::SAMPLE_BITS-1:0] offset_next;
  logic                             active;
  logic                             active_next;
  logic                             downward;
  logic                             downward_next;
  logic [sgzf_pkg::STATUS_W-1:0]    status;
  logic [sgzf_pkg::SAMPLE_BITS-1:0] s;

  always_comb begin
    s             = item.sample;
    duty_next     = duty;
    offset_next   = offset;
    active_next   = active;
    downward_next = downward;
    status        = sgzf_pkg::ST_IGNORED;
    work.clean    = '0;
    unique case (item.req_type)
      sgzf_pkg::REQ_MEASURE: begin
        status     = sgzf_pkg::ST_MEASURED;
        work.clean = (s >= offset) ? s - offset : '0;
      end
      sgzf_pkg::REQ_START: begin
        if (s == zero_upper) begin
          active_next = 1'b0;
          status      = sgzf_pkg::ST_DONE;
        end else begin
          active_next   = 1'b1;
          downward_next = s > zero_upper;
          status        = sgzf_pkg::ST_BUSY;
        end
      end
      sgzf_pkg::REQ_STEP: begin
        if (!active) begin
          status = sgzf_pkg::ST_IGNORED;
        end else if (downward) begin
          if (s <= zero_lower) begin
            offset_next = s;
            active_next = 1'b0;
            status      = sgzf_pkg::ST_DONE;
          end else if (duty == '0) begin
            status = sgzf_pkg::ST_LIMIT;
          end else begin
            duty_next = duty - 1'b1;
            status    = sgzf_pkg::ST_BUSY;
          end
        end else begin
          if (s >= zero_upper) begin
            offset_next = s;
            active_next = 1'b0;
            status      = sgzf_pkg::ST_DONE;
          end else if (duty == sgzf_pkg::DUTY_MAX) begin
            status = sgzf_pkg::ST_LIMIT;
          end else begin
            duty_next = duty + 1'b1;
            status    = sgzf_pkg::ST_BUSY;
          end
        end
      end
      default: begin
        status = sgzf_pkg::ST_IGNORED;
      end
    endcase
    work.tag.duty   = duty_next;
    work.tag.offset = offset_next;
    work.tag.status = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain       <= '0;
      zero_upper <= sgzf_pkg::ZERO_UPPER_RST;
      zero_lower <= sgzf_pkg::ZERO_LOWER_RST;
      duty       <= '0;
      offset     <= '0;
      active     <= 1'b0;
      downward   <= 1'b0;
    end else begin
      if (take) begin
        duty     <= duty_next;
        offset   <= offset_next;
        active   <= active_next;
        downward <= downward_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          sgzf_pkg::CFG_GAIN:           gain <= cfg_data[sgzf_pkg::GAIN_W-1:0];
          sgzf_pkg::CFG_DUTY_INITIAL:   duty <= cfg_data[sgzf_pkg::DUTY_W-1:0];
          sgzf_pkg::CFG_OFFSET_INITIAL: offset <= cfg_data[sgzf_pkg::SAMPLE_BITS-1:0];
          sgzf_pkg::CFG_ZERO_UPPER:     zero_upper <= cfg_data[sgzf_pkg::SAMPLE_BITS-1:0];
          sgzf_pkg::CFG_ZERO_LOWER:     zero_lower <= cfg_data[sgzf_pkg::SAMPLE_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* src/sgzf_scale.sv */
module sgzf_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sgzf_pkg::GAIN_W-1:0] gain,
  input  logic                        load_valid,
  output logic                        load_ready,
  input  sgzf_pkg::work_t             work,
  output logic                        res_valid,
  input  logic                        res_stall,
  output sgzf_pkg::res_t              res
);

  localparam int PROD_W      = sgzf_pkg::SAMPLE_BITS + sgzf_pkg::GAIN_W;
  localparam int DIV_W       = PROD_W - 3;
  localparam int RECIP_SHIFT = DIV_W + 7;
  localparam int RECIP_W     = DIV_W + 1;
  localparam int Q_W         = DIV_W - 6;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RECIP_SHIFT) + 64'd124) / 64'd125;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic                             v1;
  logic                             v2;
  logic                             v3;
  logic                             rdy2;
  logic                             rdy3;
  logic                             rdy4;
  logic [sgzf_pkg::SAMPLE_BITS-1:0] clean1;
  sgzf_pkg::tag_t                   tag1;
  sgzf_pkg::tag_t                   tag2;
  sgzf_pkg::tag_t                   tag3;
  logic [PROD_W-1:0]                prod2;
  logic [DIV_W+RECIP_W-1:0]         mul3;
  logic [Q_W-1:0]                   q3;
  logic [31:0]                      q_ext;
  logic                             sat;

  assign rdy4       = !res_valid || !res_stall;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign load_ready = !v1 || rdy2;

  // divide by 1000: shift out the factor of 8, then exact reciprocal of 125
  assign mul3  = prod2[PROD_W-1:3] * RECIP;
  assign q_ext = 32'(q3);
  assign sat   = q_ext > 32'(sgzf_pkg::FORCE_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (load_ready) v1 <= load_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) res_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      clean1 <= work.clean;
      tag1   <= work.tag;
    end
    if (rdy2 && v1) begin
      prod2 <= PROD_W'(clean1) * PROD_W'(gain);
      tag2  <= tag1;
    end
    if (rdy3 && v2) begin
      q3   <= mul3[RECIP_SHIFT +: Q_W];
      tag3 <= tag2;
    end
    if (rdy4 && v3) begin
      res.force_res       <= sat ? sgzf_pkg::FORCE_MAX : q_ext[sgzf_pkg::FORCE_W-1:0];
      res.force_saturated <= sat;
      res.bias_duty       <= tag3.duty;
      res.zero_offset     <= tag3.offset;
      res.status          <= tag3.status;
    end
  end

endmodule

/* src/strain_gauge_zero_and_force.sv */
// path: an accepted item passes the input, product, quotient and result registers to res
// throughput: one item per cycle unless res_stall holds the pipeline, through the two
// registered multiplier stages (gain product, then reciprocal of 1000) that run as a pipeline
// reset: synchronous, active high; clears the pipeline, zeroing state, duty and
// offset, gain to 0 and thresholds to 200 and 190
module strain_gauge_zero_and_force (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sgzf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgzf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  sgzf_pkg::req_t                  req,
  output logic                            res_valid,
  input  logic                            res_stall,
  output sgzf_pkg::res_t                  res
);

  logic                        load_ready;
  logic                        take;
  sgzf_pkg::work_t             work;
  logic [sgzf_pkg::GAIN_W-1:0] gain;

  assign req_stall = !load_ready;
  assign take      = req_valid && load_ready;

  sgzf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (req),
    .work      (work),
    .gain      (gain)
  );

  sgzf_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .gain       (gain),
    .load_valid (req_valid),
    .load_ready (load_ready),
    .work       (work),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

endmodule

/* src/sgzf_checker.sv */
module sgzf_checker (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input sgzf_pkg::res_t res
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled item changed");

  a_zero_force: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != sgzf_pkg::ST_MEASURED |->
      res.force_res == '0 && !res.force_saturated)
    else $error("force on a non-measure item");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.force_saturated |-> res.force_res == sgzf_pkg::FORCE_MAX)
    else $error("saturated force not at maximum");

  a_limit_duty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == sgzf_pkg::ST_LIMIT |->
      res.bias_duty == '0 || res.bias_duty == sgzf_pkg::DUTY_MAX)
    else $error("duty limit reported away from a limit");

endmodule

bind strain_gauge_zero_and_force sgzf_checker u_sgzf_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SAMPLE_MAX = (1 << sgzf_pkg::SAMPLE_BITS) - 1;
  localparam int unsigned DIVISOR = 1000;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    bit                     typed;
    sgzf_pkg::res_t         want;
  } fixed_t;

  typedef struct {
    bit                                is_cfg;
    logic [sgzf_pkg::CFG_IDX_W-1:0]    idx;
    logic [sgzf_pkg::CFG_DATA_W-1:0]   data;
    sgzf_pkg::req_t                    item;
    bit                                typed;
    sgzf_pkg::res_t                    want;
  } plan_row_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [sgzf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sgzf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            req_valid = 1'b0;
  logic                            req_stall;
  sgzf_pkg::req_t                  req = '0;
  logic                            res_valid;
  logic                            res_stall = 1'b0;
  sgzf_pkg::res_t                  res;

  strain_gauge_zero_and_force dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor copy of configuration and zeroing state
  logic [sgzf_pkg::GAIN_W-1:0]      gain_now;
  logic [sgzf_pkg::DUTY_W-1:0]      duty_now;
  logic [sgzf_pkg::SAMPLE_BITS-1:0] offset_now;
  logic [sgzf_pkg::SAMPLE_BITS-1:0] upper_now;
  logic [sgzf_pkg::SAMPLE_BITS-1:0] lower_now;
  bit                               zeroing;
  bit                               downward;

  sgzf_pkg::res_t pending_res[$];
  fixed_t         fixed_res_q[$];
  plan_row_t      plan[$];
  fixed_t         head;
  sgzf_pkg::res_t predicted;
  int             mismatches = 0;
  int             cycle_count = 0;
  int             idle_pct = 0;
  int             stall_pct = 0;

  function automatic sgzf_pkg::res_t predict_force(sgzf_pkg::req_t r);
    sgzf_pkg::res_t                   o;
    logic [sgzf_pkg::SAMPLE_BITS-1:0] clean;
    logic [31:0]                      q;
    o = '0;
    case (r.req_type)
      sgzf_pkg::REQ_MEASURE: begin
        clean = (r.sample >= offset_now) ? r.sample - offset_now : '0;
        q = (32'(clean) * 32'(gain_now)) / DIVISOR;
        if (q > 32'(sgzf_pkg::FORCE_MAX)) begin
          o.force_res = sgzf_pkg::FORCE_MAX;
          o.force_saturated = 1'b1;
        end else begin
          o.force_res = q[sgzf_pkg::FORCE_W-1:0];
        end
        o.status = sgzf_pkg::ST_MEASURED;
      end
      sgzf_pkg::REQ_START: begin
        if (r.sample == upper_now) begin
          zeroing = 1'b0;
          o.status = sgzf_pkg::ST_DONE;
        end else begin
          zeroing = 1'b1;
          downward = (r.sample > upper_now);
          o.status = sgzf_pkg::ST_BUSY;
        end
      end
      sgzf_pkg::REQ_STEP: begin
        if (!zeroing) begin
          o.status = sgzf_pkg::ST_IGNORED;
        end else if (downward) begin
          if (r.sample <= lower_now) begin
            offset_now = r.sample;
            zeroing = 1'b0;
            o.status = sgzf_pkg::ST_DONE;
          end else if (duty_now == '0) begin
            o.status = sgzf_pkg::ST_LIMIT;
          end else begin
            duty_now = duty_now - 1'b1;
            o.status = sgzf_pkg::ST_BUSY;
          end
        end else begin
          if (r.sample >= upper_now) begin
            offset_now = r.sample;
            zeroing = 1'b0;
            o.status = sgzf_pkg::ST_DONE;
          end else if (duty_now == sgzf_pkg::DUTY_MAX) begin
            o.status = sgzf_pkg::ST_LIMIT;
          end else begin
            duty_now = duty_now + 1'b1;
            o.status = sgzf_pkg::ST_BUSY;
          end
        end
      end
      default: o.status = sgzf_pkg::ST_IGNORED;
    endcase
    o.bias_duty = duty_now;
    o.zero_offset = offset_now;
    return o;
  endfunction

  function automatic void apply_cfg(logic [sgzf_pkg::CFG_IDX_W-1:0] idx,
                                    logic [sgzf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sgzf_pkg::CFG_GAIN:           gain_now = data[sgzf_pkg::GAIN_W-1:0];
      sgzf_pkg::CFG_DUTY_INITIAL:   duty_now = data[sgzf_pkg::DUTY_W-1:0];
      sgzf_pkg::CFG_OFFSET_INITIAL: offset_now = data[sgzf_pkg::SAMPLE_BITS-1:0];
      sgzf_pkg::CFG_ZERO_UPPER:     upper_now = data[sgzf_pkg::SAMPLE_BITS-1:0];
      sgzf_pkg::CFG_ZERO_LOWER:     lower_now = data[sgzf_pkg::SAMPLE_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_res(sgzf_pkg::res_t got, sgzf_pkg::res_t want);
    if (got.force_res !== want.force_res) begin
      $display("%0t force_res expected %0d actual %0d", $time, want.force_res, got.force_res);
      mismatches++;
    end
    if (got.force_saturated !== want.force_saturated) begin
      $display("%0t force_saturated expected %0d actual %0d", $time,
               want.force_saturated, got.force_saturated);
      mismatches++;
    end
    if (got.bias_duty !== want.bias_duty) begin
      $display("%0t bias_duty expected %0d actual %0d", $time, want.bias_duty, got.bias_duty);
      mismatches++;
    end
    if (got.zero_offset !== want.zero_offset) begin
      $display("%0t zero_offset expected %0d actual %0d", $time,
               want.zero_offset, got.zero_offset);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gain_now <= '0;
      duty_now <= '0;
      offset_now <= '0;
      upper_now <= sgzf_pkg::ZERO_UPPER_RST;
      lower_now <= sgzf_pkg::ZERO_LOWER_RST;
      zeroing <= 1'b0;
      downward <= 1'b0;
    end else begin
      if (cfg_we === 1'b1) apply_cfg(cfg_index, cfg_data);
      if (req_valid && req_stall === 1'b0) begin
        predicted = predict_force(req);
        if (fixed_res_q.size() != 0) begin
          head = fixed_res_q.pop_front();
          pending_res.push_back(head.typed ? head.want : predicted);
        end else begin
          pending_res.push_back(predicted);
        end
      end
      if (res_valid === 1'b1 && !res_stall) begin
        if (pending_res.size() == 0) begin
          $display("%0t unexpected item: expected none actual %h", $time, res);
          mismatches++;
        end else begin
          compare_res(res, pending_res.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) res_stall <= ($urandom_range(99) < stall_pct);

  function automatic sgzf_pkg::req_t mk_req(logic [1:0] t,
                                            logic [sgzf_pkg::SAMPLE_BITS-1:0] s);
    sgzf_pkg::req_t r;
    r.req_type = t;
    r.sample = s;
    return r;
  endfunction

  task automatic add_cfg(logic [sgzf_pkg::CFG_IDX_W-1:0] idx,
                         logic [sgzf_pkg::CFG_DATA_W-1:0] data);
    plan_row_t p;
    p = '{1'b1, idx, data, '0, 1'b0, '0};
    plan.push_back(p);
  endtask

  task automatic add_item(logic [1:0] t, int s);
    plan_row_t p;
    p = '{1'b0, '0, '0, mk_req(t, s[sgzf_pkg::SAMPLE_BITS-1:0]), 1'b0, '0};
    plan.push_back(p);
  endtask

  task automatic add_typed(logic [1:0] t, int s, int f, bit sat, int duty, int off,
                           logic [sgzf_pkg::STATUS_W-1:0] st);
    plan_row_t      p;
    sgzf_pkg::res_t w;
    w.force_res = f[sgzf_pkg::FORCE_W-1:0];
    w.force_saturated = sat;
    w.bias_duty = duty[sgzf_pkg::DUTY_W-1:0];
    w.zero_offset = off[sgzf_pkg::SAMPLE_BITS-1:0];
    w.status = st;
    p = '{1'b0, '0, '0, mk_req(t, s[sgzf_pkg::SAMPLE_BITS-1:0]), 1'b1, w};
    plan.push_back(p);
  endtask

  // called right after a negedge; lowers valid and lets the pipeline empty
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(logic [sgzf_pkg::CFG_IDX_W-1:0] idx,
                           logic [sgzf_pkg::CFG_DATA_W-1:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(sgzf_pkg::req_t r, bit typed, sgzf_pkg::res_t want);
    fixed_res_q.push_back('{typed, want});
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_rand(logic [1:0] t, int s);
    send_item(mk_req(t, s[sgzf_pkg::SAMPLE_BITS-1:0]), 1'b0, '0);
  endtask

  function automatic int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  // half the time near the thresholds and the offset, where the behavior turns
  function automatic int pick_sample();
    int v;
    case ($urandom_range(5))
      0, 1: v = $urandom_range(SAMPLE_MAX);
      2: v = int'(upper_now) + int'($urandom_range(4)) - 2;
      3: v = int'(lower_now) + int'($urandom_range(4)) - 2;
      4: v = int'(offset_now) + int'($urandom_range(40)) - 20;
      default: v = $urandom_range(1) ? SAMPLE_MAX : 0;
    endcase
    return clamp_sample(v);
  endfunction

  function automatic logic [sgzf_pkg::CFG_DATA_W-1:0] pick_reg(int maxv);
    int v;
    case ($urandom_range(5))
      0: v = 0;
      1: v = maxv;
      2: v = 1;
      3: v = maxv - 1;
      default: v = $urandom_range(maxv);
    endcase
    // unused upper data bits
    if ($urandom_range(3) == 0) v = v | (int'($urandom_range(65535)) & ~maxv);
    return v[sgzf_pkg::CFG_DATA_W-1:0];
  endfunction

  task automatic random_config();
    int up;
    cfg_write(sgzf_pkg::CFG_GAIN, $urandom_range(3) == 0 ? 16'(DIVISOR) : pick_reg(65535));
    cfg_write(sgzf_pkg::CFG_DUTY_INITIAL, pick_reg(sgzf_pkg::DUTY_MAX));
    cfg_write(sgzf_pkg::CFG_OFFSET_INITIAL,
              $urandom_range(2) == 0 ? pick_reg(SAMPLE_MAX) : 16'($urandom_range(300)));
    up = $urandom_range(3) == 0 ? int'(pick_reg(SAMPLE_MAX)) : int'($urandom_range(SAMPLE_MAX));
    cfg_write(sgzf_pkg::CFG_ZERO_UPPER, up[sgzf_pkg::CFG_DATA_W-1:0]);
    if ($urandom_range(1) == 0)
      cfg_write(sgzf_pkg::CFG_ZERO_LOWER, pick_reg(SAMPLE_MAX));
    else
      cfg_write(sgzf_pkg::CFG_ZERO_LOWER,
                16'(clamp_sample((up & SAMPLE_MAX) - int'($urandom_range(15)))));
    if ($urandom_range(3) == 0)
      cfg_write(sgzf_pkg::CFG_ZERO_LOWER + 3'($urandom_range(1, 3)),
                16'($urandom_range(65535)));
  endtask

  task automatic run_segment(int n);
    int sent;
    int steps;
    int s;
    bit down;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          send_rand(sgzf_pkg::REQ_MEASURE,
                    $urandom_range(1) ? pick_sample() : $urandom_range(SAMPLE_MAX));
          sent++;
        end
        9: begin
          send_rand(2'($urandom_range(3)), $urandom_range(SAMPLE_MAX));
          sent++;
        end
        default: begin
          // zeroing run: start, then steps that mostly stay on the near side
          s = pick_sample();
          down = (s > int'(upper_now));
          send_rand(sgzf_pkg::REQ_START, s);
          sent++;
          steps = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
          repeat (steps) begin
            if ($urandom_range(9) == 0) begin
              send_rand(sgzf_pkg::REQ_MEASURE, pick_sample());
              sent++;
            end
            if ($urandom_range(3) == 0)
              s = pick_sample();
            else if (down && lower_now != SAMPLE_MAX)
              s = $urandom_range(SAMPLE_MAX, int'(lower_now) + 1);
            else if (!down && upper_now != 0)
              s = $urandom_range(int'(upper_now) - 1, 0);
            else
              s = pick_sample();
            send_rand(sgzf_pkg::REQ_STEP, s);
            sent++;
          end
        end
      endcase
    end
  endtask

  initial begin
    add_typed(sgzf_pkg::REQ_MEASURE, 1023, 0, 0, 0, 0, sgzf_pkg::ST_MEASURED);
    add_typed(sgzf_pkg::REQ_STEP, 5, 0, 0, 0, 0, sgzf_pkg::ST_IGNORED);
    add_typed(REQ_UNUSED, 1023, 0, 0, 0, 0, sgzf_pkg::ST_IGNORED);
    add_cfg(sgzf_pkg::CFG_GAIN, 16'hFFFF);
    add_typed(sgzf_pkg::REQ_MEASURE, 1023, sgzf_pkg::FORCE_MAX, 1, 0, 0, sgzf_pkg::ST_MEASURED);
    add_typed(sgzf_pkg::REQ_MEASURE, 0, 0, 0, 0, 0, sgzf_pkg::ST_MEASURED);
    add_typed(sgzf_pkg::REQ_MEASURE, 1, 65, 0, 0, 0, sgzf_pkg::ST_MEASURED);
    add_cfg(sgzf_pkg::CFG_OFFSET_INITIAL, 16'd1023);
    add_typed(sgzf_pkg::REQ_MEASURE, 1000, 0, 0, 0, 1023, sgzf_pkg::ST_MEASURED);
    add_typed(sgzf_pkg::REQ_MEASURE, 1023, 0, 0, 0, 1023, sgzf_pkg::ST_MEASURED);
    add_cfg(sgzf_pkg::CFG_OFFSET_INITIAL, 16'd0);
    add_typed(sgzf_pkg::REQ_START, 200, 0, 0, 0, 0, sgzf_pkg::ST_DONE);
    add_typed(sgzf_pkg::REQ_START, 201, 0, 0, 0, 0, sgzf_pkg::ST_BUSY);
    add_typed(sgzf_pkg::REQ_STEP, 500, 0, 0, 0, 0, sgzf_pkg::ST_LIMIT);
    add_item(sgzf_pkg::REQ_MEASURE, 300);
    add_item(sgzf_pkg::REQ_STEP, 190);
    add_cfg(sgzf_pkg::CFG_DUTY_INITIAL, 16'd255);
    add_item(sgzf_pkg::REQ_START, 0);
    add_typed(sgzf_pkg::REQ_STEP, 100, 0, 0, 255, 190, sgzf_pkg::ST_LIMIT);
    add_cfg(sgzf_pkg::CFG_DUTY_INITIAL, 16'd254);
    add_item(sgzf_pkg::REQ_STEP, 199);
    add_item(sgzf_pkg::REQ_STEP, 199);
    add_item(sgzf_pkg::REQ_START, 1023);
    add_item(sgzf_pkg::REQ_STEP, 1023);
    add_item(sgzf_pkg::REQ_STEP, 0);
    add_cfg(sgzf_pkg::CFG_ZERO_UPPER, 16'd0);
    add_cfg(sgzf_pkg::CFG_ZERO_LOWER, 16'd1023);
    add_item(sgzf_pkg::REQ_START, 0);
    add_item(sgzf_pkg::REQ_START, 1023);
    add_item(sgzf_pkg::REQ_STEP, 1023);
    add_cfg(sgzf_pkg::CFG_ZERO_UPPER, 16'd1023);
    add_cfg(sgzf_pkg::CFG_ZERO_LOWER, 16'd0);
    add_item(sgzf_pkg::REQ_START, 500);
    add_item(sgzf_pkg::REQ_STEP, 1023);
    add_cfg(sgzf_pkg::CFG_ZERO_LOWER + 3'd1, 16'hFFFF);
    add_item(sgzf_pkg::REQ_MEASURE, 700);

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        cfg_write(plan[i].idx, plan[i].data);
      else
        send_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        random_config();
        run_segment(56);
      end
    end

    req_valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
